@@ rtl/core/bbsf_pkg.sv @@
// ----------------------------------------------------------------------------
// bbsf_pkg
// Shared types and codes of the buffer binding state filter.
// ----------------------------------------------------------------------------
`default_nettype none

package bbsf_pkg;

  localparam int unsigned MODE_W = 2;
  localparam int unsigned TGT_W  = 3;
  localparam int unsigned SLOT_W = 8;
  localparam int unsigned BUF_W  = 32;

  localparam int unsigned NUM_TARGETS = 4;

  localparam logic [MODE_W-1:0] MODE_BIND       = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BIND_RANGE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR      = 2'd3;

  localparam logic [1:0]       TGT_STORAGE = 2'd2;
  localparam logic [TGT_W-1:0] TGT_STORAGE_CODE = 3'd2;

  localparam int unsigned S_TDATA_W = 112;
  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned M_TDATA_W = 8;
  localparam int unsigned M_TUSER_W = 1;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [TGT_W-1:0]  target;
    logic [SLOT_W-1:0] slot;
    logic [BUF_W-1:0]  buffer_id;
    logic [BUF_W-1:0]  range_offset;
    logic [BUF_W-1:0]  range_size;
  } cmd_t;

  typedef struct packed {
    logic forward;
    logic bad_target;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/core/bbsf_state.sv @@
// ----------------------------------------------------------------------------
// bbsf_state
// Binding cache: per-target buffers and range slot table, updated once per
// command, with the forward / bad target decision for that command.
// ----------------------------------------------------------------------------
`default_nettype none

module bbsf_state
  import bbsf_pkg::*;
#(
  parameter int unsigned RANGE_SLOTS = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic go,
  input  wire cmd_t cmd,
  output res_t      res
);

  localparam int unsigned IDX_W = (RANGE_SLOTS > 1) ? $clog2(RANGE_SLOTS) : 1;

  logic [BUF_W-1:0] bound       [NUM_TARGETS];
  logic [BUF_W-1:0] slot_buffer [RANGE_SLOTS];
  logic [BUF_W-1:0] slot_offset [RANGE_SLOTS];
  logic [BUF_W-1:0] slot_size   [RANGE_SLOTS];

  logic [1:0]       tgt_idx;
  logic [IDX_W-1:0] slot_idx;
  logic             tgt_ok;
  logic             bind_hit;
  logic             cached;
  logic             range_same;

  assign tgt_idx  = cmd.target[1:0];
  assign slot_idx = cmd.slot[IDX_W-1:0];
  assign tgt_ok   = (cmd.target < TGT_W'(NUM_TARGETS));
  assign bind_hit = (bound[tgt_idx] == cmd.buffer_id);
  assign cached   = (cmd.target == TGT_STORAGE_CODE) && (cmd.slot < SLOT_W'(RANGE_SLOTS));
  assign range_same = cached &&
                      (slot_buffer[slot_idx] == cmd.buffer_id) &&
                      (slot_offset[slot_idx] == cmd.range_offset) &&
                      (slot_size[slot_idx] == cmd.range_size);

  always_comb begin
    res = '0;
    case (cmd.mode)
      MODE_BIND: begin
        res.bad_target = !tgt_ok;
        res.forward    = tgt_ok && !bind_hit;
      end
      MODE_BIND_RANGE: begin
        res.forward = !range_same;
      end
      MODE_DELETE: begin
        res.forward = 1'b1;
      end
      MODE_CLEAR: begin
        res.forward = 1'b1;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TARGETS; i++) bound[i] <= '0;
      for (int i = 0; i < RANGE_SLOTS; i++) begin
        slot_buffer[i] <= '0;
        slot_offset[i] <= '0;
        slot_size[i]   <= '0;
      end
    end else if (go) begin
      case (cmd.mode)
        MODE_BIND: begin
          if (res.forward) bound[tgt_idx] <= cmd.buffer_id;
        end
        MODE_BIND_RANGE: begin
          if (cached && !range_same) begin
            slot_buffer[slot_idx] <= cmd.buffer_id;
            slot_offset[slot_idx] <= cmd.range_offset;
            slot_size[slot_idx]   <= cmd.range_size;
          end
          if (res.forward) bound[TGT_STORAGE] <= cmd.buffer_id;
        end
        MODE_DELETE: begin
          for (int i = 0; i < NUM_TARGETS; i++) begin
            if (bound[i] == cmd.buffer_id) bound[i] <= '0;
          end
          for (int i = 0; i < RANGE_SLOTS; i++) begin
            if (slot_buffer[i] == cmd.buffer_id) slot_buffer[i] <= '0;
          end
        end
        MODE_CLEAR: begin
          for (int i = 0; i < NUM_TARGETS; i++) bound[i] <= '0;
          for (int i = 0; i < RANGE_SLOTS; i++) slot_buffer[i] <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  a_bind_records: assert property (@(posedge clk) disable iff (rst)
    go && (cmd.mode == MODE_BIND) && res.forward
    |=> bound[$past(tgt_idx)] == $past(cmd.buffer_id))
    else $error("forwarded bind not recorded");

  a_range_records: assert property (@(posedge clk) disable iff (rst)
    go && (cmd.mode == MODE_BIND_RANGE) && res.forward
    |=> bound[TGT_STORAGE] == $past(cmd.buffer_id))
    else $error("forwarded range bind not recorded for storage target");

  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    go && (cmd.mode == MODE_CLEAR)
    |=> (bound[0] == '0) && (bound[1] == '0) && (bound[2] == '0) && (bound[3] == '0))
    else $error("clear left a target bound");

  a_delete_drops: assert property (@(posedge clk) disable iff (rst)
    go && (cmd.mode == MODE_DELETE)
    |=> bound[TGT_STORAGE] != $past(cmd.buffer_id) || $past(cmd.buffer_id) == '0)
    else $error("delete left storage target bound to deleted buffer");

endmodule

`default_nettype wire

@@ rtl/core/buffer_binding_state_filter.sv @@
// ----------------------------------------------------------------------------
// buffer_binding_state_filter
// Drops redundant buffer binding commands from a command stream.
//
// Input channel s_axis: one command word per handshake; tuser carries the
// command mode, tdata the target, slot, buffer and range fields.
// Output channel m_axis: one result word per command, in order; tdata[0]
// is the forward flag, tuser[0] flags an unsupported bind target.
// A command passes the input register, then the result register.
// Throughput: one command per cycle while m_axis_tready is high; the
// per-command decision and cache update fit between the input register
// and the result register.
// Reset: clears both registers' valid flags and zeroes all bound buffers
// and every cached range slot.
// Stall: when m_axis_tready is low the result holds; one more command may
// sit in the input register, after which s_axis_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module buffer_binding_state_filter
  import bbsf_pkg::*;
#(
  parameter int unsigned RANGE_SLOTS = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // target[2:0], slot[10:3], buffer_id[42:11], range_offset[74:43],
  // range_size[106:75], zero pad[111:107]
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
  // mode[1:0]
  input  wire logic [S_TUSER_W-1:0] s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // forward[0], zero pad[7:1]
  output logic [M_TDATA_W-1:0]      m_axis_tdata,
  // bad_target[0]
  output logic [M_TUSER_W-1:0]      m_axis_tuser
);

  logic in_valid;
  cmd_t in_cmd;
  res_t res_calc;
  res_t out_res;
  logic move;
  logic accept;

  assign move          = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || move;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (accept) begin
      in_valid <= 1'b1;
    end else if (move) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_cmd.mode         <= s_axis_tuser[1:0];
      in_cmd.target       <= s_axis_tdata[2:0];
      in_cmd.slot         <= s_axis_tdata[10:3];
      in_cmd.buffer_id    <= s_axis_tdata[42:11];
      in_cmd.range_offset <= s_axis_tdata[74:43];
      in_cmd.range_size   <= s_axis_tdata[106:75];
    end
  end

  bbsf_state #(
    .RANGE_SLOTS(RANGE_SLOTS)
  ) u_state (
    .clk (clk),
    .rst (rst),
    .go  (move),
    .cmd (in_cmd),
    .res (res_calc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (move) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) out_res <= res_calc;
  end

  assign m_axis_tdata = {{(M_TDATA_W-1){1'b0}}, out_res.forward};
  assign m_axis_tuser = out_res.bad_target;

endmodule

`default_nettype wire
